/* src/ehpt_pkg.sv */
`timescale 1ns / 1ps

package ehpt_pkg;

  localparam int TimeBits = 32;
  localparam int CoordW   = 32;
  localparam int DeltaW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CmpW     = (TimeBits > CoordW) ? TimeBits : CoordW;
  localparam int QuotW    = 16;
  localparam int DivCntW  = 4;

  localparam logic [18:0] ThreeQ = 19'd196608;
  localparam logic [18:0] OneQ   = 19'd65536;

  localparam logic signed [34:0] SatHi = 35'sd2147483647;
  localparam logic signed [34:0] SatLo = -35'sd2147483648;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_START_Z  = 3'd2,
    REG_END_X    = 3'd3,
    REG_END_Y    = 3'd4,
    REG_END_Z    = 3'd5,
    REG_DURATION = 3'd6,
    REG_HOP      = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_TT  = 3'd0,
    MUL_E   = 3'd1,
    MUL_H   = 3'd2,
    MUL_X   = 3'd3,
    MUL_Y   = 3'd4,
    MUL_Z   = 3'd5,
    MUL_HOP = 3'd6
  } mul_op_e;

  typedef struct packed {
    logic    acc;
    logic    div_init;
    logic    div_step;
    logic    mul_en;
    mul_op_e mul_op;
    logic    out_load;
    logic    out_fin;
  } cmd_t;

  typedef struct packed {
    logic fin;
  } status_t;

endpackage

/* src/ehpt_ctrl.sv */
`timescale 1ns / 1ps

module ehpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ehpt_pkg::status_t status_i,
  output ehpt_pkg::cmd_t    cmd_o
);
  import ehpt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [DivCntW-1:0]   cnt_q;
  logic                 fin_q;
  logic                 out_valid_q;
  logic                 out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_op   = MUL_TT;
    cmd_o.out_fin  = fin_q;
    unique case (state_q)
      ST_IDLE:  cmd_o.acc = in_valid_i;
      ST_CHECK: cmd_o.div_init = !status_i.fin;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = mul_op_e'(cnt_q[2:0]);
      end
      ST_OUT:   cmd_o.out_load = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          fin_q <= status_i.fin;
          cnt_q <= '0;
          state_q <= status_i.fin ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == DivCntW'(QuotW - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[2:0] == MUL_HOP) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/ehpt_dp.sv */
`timescale 1ns / 1ps

module ehpt_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ehpt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ehpt_pkg::CoordW-1:0]       cfg_data_i,
  input  logic [ehpt_pkg::DeltaW-1:0]       delta_ms_i,
  input  ehpt_pkg::cmd_t                    cmd_i,
  output ehpt_pkg::status_t                 status_o,
  output logic signed [ehpt_pkg::CoordW-1:0] pos_x_o,
  output logic signed [ehpt_pkg::CoordW-1:0] pos_y_o,
  output logic signed [ehpt_pkg::CoordW-1:0] pos_z_o,
  output logic                              finished_o
);
  import ehpt_pkg::*;

  logic [CoordW-1:0]   regs_q [8];
  logic [TimeBits-1:0] elapsed_q;
  logic [TimeBits:0]   elapsed_sum;
  logic [CoordW-1:0]   dur;
  logic [CmpW-1:0]     elapsed_ext;

  logic [CoordW-1:0]   rem_q;
  logic [CoordW:0]     rem2;
  logic                rem_ge;
  logic [QuotW-1:0]    t_q;

  logic signed [CoordW:0] dx_q, dy_q, dz_q;
  logic [31:0]            tt_q;
  logic [16:0]            e_q;
  logic [16:0]            h_q;
  logic [31:0]            qx_q, qz_q;
  logic signed [33:0]     qy_q;
  logic signed [32:0]     qhop_q;

  logic signed [33:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [52:0] mul_p;
  logic signed [34:0] y_sum;
  logic [CoordW-1:0]  y_sat;

  logic signed [CoordW-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic                     finished_q;

  // effective duration, zero acts as one
  assign dur = (regs_q[REG_DURATION] == '0) ? CoordW'(1) : regs_q[REG_DURATION];

  assign elapsed_sum = {1'b0, elapsed_q} + (TimeBits + 1)'(delta_ms_i);
  assign elapsed_ext = CmpW'(elapsed_q);
  assign status_o.fin = elapsed_ext >= CmpW'(dur);

  assign rem2   = {rem_q, 1'b0};
  assign rem_ge = rem2 >= {1'b0, dur};

  always_comb begin
    case (cmd_i.mul_op)
      MUL_TT: begin
        mul_a = {18'd0, t_q};
        mul_b = {3'd0, t_q};
      end
      MUL_E: begin
        mul_a = {2'd0, tt_q};
        mul_b = ThreeQ - {2'd0, t_q, 1'b0};
      end
      MUL_H: begin
        mul_a = {18'd0, t_q};
        mul_b = OneQ - {3'd0, t_q};
      end
      MUL_X: begin
        mul_a = {dx_q[CoordW], dx_q};
        mul_b = {2'd0, e_q};
      end
      MUL_Y: begin
        mul_a = {dy_q[CoordW], dy_q};
        mul_b = {2'd0, e_q};
      end
      MUL_Z: begin
        mul_a = {dz_q[CoordW], dz_q};
        mul_b = {2'd0, e_q};
      end
      MUL_HOP: begin
        mul_a = {{2{regs_q[REG_HOP][CoordW-1]}}, regs_q[REG_HOP]};
        mul_b = {2'd0, h_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // lerp y plus hop, clamped to the signed 32-bit range
  always_comb begin
    y_sum = {{3{regs_q[REG_START_Y][CoordW-1]}}, regs_q[REG_START_Y]}
          + {qy_q[33], qy_q}
          + {{2{qhop_q[32]}}, qhop_q};
    if (y_sum > SatHi) begin
      y_sat = {1'b0, {(CoordW-1){1'b1}}};
    end else if (y_sum < SatLo) begin
      y_sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      y_sat = y_sum[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= (i == REG_DURATION) ? CoordW'(1) : '0;
      end
      elapsed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        regs_q[cfg_idx_i] <= cfg_data_i;
      end
      if (cmd_i.acc) begin
        // saturating elapsed counter
        elapsed_q <= elapsed_sum[TimeBits] ? '1 : elapsed_sum[TimeBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= elapsed_ext[CoordW-1:0];
      t_q   <= '0;
      dx_q  <= {regs_q[REG_END_X][CoordW-1], regs_q[REG_END_X]}
             - {regs_q[REG_START_X][CoordW-1], regs_q[REG_START_X]};
      dy_q  <= {regs_q[REG_END_Y][CoordW-1], regs_q[REG_END_Y]}
             - {regs_q[REG_START_Y][CoordW-1], regs_q[REG_START_Y]};
      dz_q  <= {regs_q[REG_END_Z][CoordW-1], regs_q[REG_END_Z]}
             - {regs_q[REG_START_Z][CoordW-1], regs_q[REG_START_Z]};
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? CoordW'(rem2 - {1'b0, dur}) : rem2[CoordW-1:0];
      t_q   <= {t_q[QuotW-2:0], rem_ge};
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_op)
        MUL_TT:  tt_q   <= mul_p[31:0];
        MUL_E:   e_q    <= mul_p[48:32];
        MUL_H:   h_q    <= mul_p[30:14];
        MUL_X:   qx_q   <= mul_p[47:16];
        MUL_Y:   qy_q   <= mul_p[49:16];
        MUL_Z:   qz_q   <= mul_p[47:16];
        MUL_HOP: qhop_q <= mul_p[48:16];
        default: tt_q   <= tt_q;
      endcase
    end
    if (cmd_i.out_load) begin
      finished_q <= cmd_i.out_fin;
      if (cmd_i.out_fin) begin
        pos_x_q <= regs_q[REG_END_X];
        pos_y_q <= regs_q[REG_END_Y];
        pos_z_q <= regs_q[REG_END_Z];
      end else begin
        pos_x_q <= regs_q[REG_START_X] + qx_q;
        pos_y_q <= y_sat;
        pos_z_q <= regs_q[REG_START_Z] + qz_q;
      end
    end
  end

  assign pos_x_o    = pos_x_q;
  assign pos_y_o    = pos_y_q;
  assign pos_z_o    = pos_z_q;
  assign finished_o = finished_q;

endmodule

/* src/eased_hop_position_tween.sv */
`timescale 1ns / 1ps
// finished path: accept, check, then load the end position into the result register
// running path: a 16-bit restoring division for t, one bit per cycle, then the steps
// on one shared multiplier (t squared, ease, arc, three lerps, hop)
// a new item is taken only in idle, once the previous one has been loaded for output
// the result register lets the next item in while a result waits to be taken
// reset: elapsed time 0, duration 1, other config registers 0, no result pending

module eased_hop_position_tween (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ehpt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ehpt_pkg::CoordW-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ehpt_pkg::DeltaW-1:0]        delta_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ehpt_pkg::CoordW-1:0] pos_x_o,
  output logic signed [ehpt_pkg::CoordW-1:0] pos_y_o,
  output logic signed [ehpt_pkg::CoordW-1:0] pos_z_o,
  output logic                               finished_o
);
  import ehpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  ehpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ehpt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .delta_ms_i (delta_ms_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .finished_o (finished_o)
  );

endmodule
